@@ rtl/fsbw_pkg.sv @@
// Shared types and constants for the device-tree structure block walker.
package fsbw_pkg;

	localparam int WORD_W   = 32;
	localparam int SIZE_W   = 21;
	localparam int OFFSET_W = 21;
	localparam int SKIP_W   = 31;
	localparam int PHASE_W  = 3;

	localparam logic [PHASE_W-1:0] PH_TOKEN   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_NAME    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_NAMEOFF = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SKIP    = 3'd4;
	localparam logic [PHASE_W-1:0] PH_HALT    = 3'd5;

	localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
	localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
	localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
	localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

	localparam logic EV_PROP  = 1'b0;
	localparam logic EV_ERROR = 1'b1;

	typedef struct packed {
		logic                event_kind;
		logic [WORD_W-1:0]   name_offset;
		logic [WORD_W-1:0]   value_length;
		logic [OFFSET_W-1:0] value_offset;
	} event_t;

	function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic has_zero_byte(input logic [WORD_W-1:0] w);
		return (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
			(w[23:16] == 8'd0) || (w[31:24] == 8'd0);
	endfunction

endpackage

@@ rtl/fsbw_parser.sv @@
// Token parser: phase state, word counter and event decode for each accepted word.
module fsbw_parser #(
	parameter int MAX_STRUCT_BYTES = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fsbw_pkg::SIZE_W-1:0]   size_bytes,
	input  logic                          accept,
	input  logic [fsbw_pkg::WORD_W-1:0]   raw_word,
	input  logic                          start_req,
	output logic                          res_valid,
	output fsbw_pkg::event_t              res
);
	import fsbw_pkg::*;

	localparam int IDX_W = $clog2(MAX_STRUCT_BYTES / 4 + 1);
	localparam int CMP_W = (IDX_W + 2 > SIZE_W) ? IDX_W + 2 : SIZE_W;

	logic [PHASE_W-1:0] phase_q, phase_d, phase_eff;
	logic [IDX_W-1:0]   idx_q, idx_d, idx_eff;
	logic [WORD_W-1:0]  len_q, len_d;
	logic [SKIP_W-1:0]  skip_q, skip_d;
	logic [CMP_W-1:0]   limit, byte_off, next_off;
	logic [WORD_W-1:0]  word;
	logic               active;

	always_comb begin
		word      = byte_swap(raw_word);
		phase_eff = start_req ? PH_TOKEN : phase_q;
		idx_eff   = start_req ? '0 : idx_q;
		if (CMP_W'(size_bytes) > CMP_W'(MAX_STRUCT_BYTES)) begin
			limit = CMP_W'(MAX_STRUCT_BYTES);
		end else begin
			limit = CMP_W'(size_bytes);
		end
		byte_off = CMP_W'({idx_eff, 2'b00});
		next_off = byte_off + CMP_W'(4);
		active   = (phase_eff != PH_HALT) && (byte_off < limit);
	end

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		len_d = len_q;
		skip_d = skip_q;
		res_valid = 1'b0;
		res.event_kind = EV_PROP;
		res.name_offset = word;
		res.value_length = len_q;
		res.value_offset = next_off[OFFSET_W-1:0];
		if (accept) begin
			phase_d = phase_eff;
			idx_d = idx_eff;
			if (active) begin
				idx_d = idx_eff + IDX_W'(1);
				case (phase_eff)
					PH_TOKEN: begin
						if (word == TOK_BEGIN_NODE) begin
							phase_d = PH_NAME;
						end else if (word == TOK_PROP) begin
							phase_d = PH_LEN;
						end else if (word == TOK_NOP || word == TOK_END_NODE ||
								word == TOK_END) begin
							phase_d = PH_TOKEN;
						end else begin
							res_valid = 1'b1;
							res.event_kind = EV_ERROR;
							res.name_offset = '0;
							res.value_length = word;
							res.value_offset = byte_off[OFFSET_W-1:0];
							phase_d = PH_HALT;
						end
					end
					PH_NAME: begin
						if (has_zero_byte(raw_word)) begin
							phase_d = PH_TOKEN;
						end
					end
					PH_LEN: begin
						len_d = word;
						phase_d = PH_NAMEOFF;
					end
					PH_NAMEOFF: begin
						res_valid = 1'b1;
						skip_d = SKIP_W'(len_q[WORD_W-1:2]) + SKIP_W'(|len_q[1:0]);
						phase_d = (skip_d != '0) ? PH_SKIP : PH_TOKEN;
					end
					PH_SKIP: begin
						skip_d = skip_q - SKIP_W'(1);
						if (skip_q == SKIP_W'(1)) begin
							phase_d = PH_TOKEN;
						end
					end
					default: begin
						phase_d = PH_HALT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			idx_q <= '0;
			len_q <= '0;
			skip_q <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			len_q <= len_d;
			skip_q <= skip_d;
		end
	end

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.event_kind == EV_ERROR |=> phase_q == PH_HALT)
		else $error("Walker did not halt after an unknown token.");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("Skip phase entered with no value words left.");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT && !start_req |-> !res_valid && phase_d == PH_HALT)
		else $error("Halted walker produced an event or left the halt without a start.");

endmodule

@@ rtl/fsbw_out_reg.sv @@
// Output register holding one event until the downstream side takes it.
module fsbw_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  fsbw_pkg::event_t load_event,
	input  logic             take,
	output logic             out_valid,
	output fsbw_pkg::event_t out_event
);
	import fsbw_pkg::*;

	logic   valid_q;
	event_t event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_q <= load_event;
		end
	end

	assign out_valid = valid_q;
	assign out_event = event_q;

endmodule

@@ rtl/fdt_struct_block_walker.sv @@
// Top level of the device-tree structure block walker.
// The walker takes one structure-block word per cycle, back to back, unless an event is
// held on the output; the token decode and the phase update sit in one short path between
// the input handshake and the event register. An event is ready on the output in the cycle
// after the word that caused it, and a new word is taken while that event waits as long as
// the downstream side takes it in the same cycle. Only PROP name-offset words and unknown
// tokens produce events; after an unknown token every word is dropped until one carries
// the start flag. Words at or beyond the configured block size in bytes, capped at
// MAX_STRUCT_BYTES, are dropped without changing state apart from the restart that a start
// flag causes. Write the block size only while the walker is idle.
module fdt_struct_block_walker #(
	parameter int MAX_STRUCT_BYTES = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data,    // block size in bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // raw_word
	input  logic [0:0]  s_tuser,     // start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,     // name_offset, value_length, value_offset, zero pad
	output logic [0:0]  m_tuser      // event_kind
);
	import fsbw_pkg::*;

	logic [SIZE_W-1:0] size_bytes_q;
	logic              accept;
	logic              res_valid;
	event_t            res;
	event_t            out_event;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_bytes_q <= '0;
		end else if (cfg_valid) begin
			size_bytes_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready = !m_tvalid || m_tready;
	assign accept = s_tvalid && s_tready;

	fsbw_parser #(
		.MAX_STRUCT_BYTES(MAX_STRUCT_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_bytes (size_bytes_q),
		.accept     (accept),
		.raw_word   (s_tdata),
		.start_req  (s_tuser[0]),
		.res_valid  (res_valid),
		.res        (res)
	);

	fsbw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && res_valid),
		.load_event(res),
		.take      (m_tready),
		.out_valid (m_tvalid),
		.out_event (out_event)
	);

	assign m_tdata = {3'b000, out_event.value_offset, out_event.value_length,
		out_event.name_offset};
	assign m_tuser = out_event.event_kind;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("Input taken while an event is stalled on the output.");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled with an empty output register.");

	a_event_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid |=> m_tvalid)
		else $error("Event lost after an accepted word.");

endmodule

@@ tb/fdt_struct_block_walker_test.sv @@
// Self-checking testbench for the device-tree structure block walker.
`timescale 1ns / 1ps

module fdt_struct_block_walker_test;
	import fsbw_pkg::*;

	localparam int MAX_BYTES = 1048576;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1900;

	typedef struct packed {
		logic [31:0] raw;
		logic        start;
	} walk_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [20:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [0:0]  m_tuser;

	walk_item_t words_q[$];
	event_t     events_due[$];
	int         words_made = 0;
	int         bad_events = 0;
	int         shown = 0;

	logic [20:0] cur_size = '0;
	logic [2:0]  ph = PH_TOKEN;
	logic [31:0] widx = '0;
	logic [31:0] plen = '0;
	logic [31:0] skip = '0;

	int   gap_left = 0;
	int   burst_left = 0;
	int   rx_mode = 0;
	int   rx_left = 0;
	int   hold_left = 0;
	int   cyc = 0;
	logic long_hold;

	fdt_struct_block_walker #(
		.MAX_STRUCT_BYTES(MAX_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advances the walker state by one accepted item and queues any event it raises.
	task automatic walk_word(input logic [31:0] raw, input logic start);
		logic [31:0] w;
		logic [31:0] lim;
		logic [31:0] idx;
		logic [31:0] off;
		event_t ev;
		w = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
		lim = (cur_size > MAX_BYTES) ? MAX_BYTES : 32'(cur_size);
		if (start) begin
			ph = PH_TOKEN;
			widx = '0;
			plen = '0;
			skip = '0;
		end
		if (ph == PH_HALT)
			return;
		if (longint'(widx) * 4 >= longint'(lim))
			return;
		idx = widx;
		widx = idx + 1;
		case (ph)
			PH_TOKEN: begin
				if (w == TOK_BEGIN_NODE) begin
					ph = PH_NAME;
				end else if (w == TOK_PROP) begin
					ph = PH_LEN;
				end else if (w == TOK_NOP || w == TOK_END_NODE || w == TOK_END) begin
					ph = PH_TOKEN;
				end else begin
					off = idx * 4;
					ev.event_kind = EV_ERROR;
					ev.name_offset = '0;
					ev.value_length = w;
					ev.value_offset = off[20:0];
					events_due.push_back(ev);
					ph = PH_HALT;
				end
			end
			PH_NAME: begin
				if (raw[7:0] == 8'd0 || raw[15:8] == 8'd0 || raw[23:16] == 8'd0 ||
						raw[31:24] == 8'd0)
					ph = PH_TOKEN;
			end
			PH_LEN: begin
				plen = w;
				ph = PH_NAMEOFF;
			end
			PH_NAMEOFF: begin
				off = (idx + 1) * 4;
				ev.event_kind = EV_PROP;
				ev.name_offset = w;
				ev.value_length = plen;
				ev.value_offset = off[20:0];
				events_due.push_back(ev);
				skip = (plen >> 2) + ((plen[1:0] != 2'd0) ? 32'd1 : 32'd0);
				ph = (skip != 0) ? PH_SKIP : PH_TOKEN;
			end
			PH_SKIP: begin
				if (skip != 0)
					skip = skip - 1;
				if (skip == 0)
					ph = PH_TOKEN;
			end
			default: begin
				ph = PH_HALT;
			end
		endcase
	endtask

	task automatic push_raw(input logic [31:0] raw, input logic start);
		walk_item_t it;
		it.raw = raw;
		it.start = start;
		words_q.push_back(it);
		words_made++;
	endtask

	task automatic push_tok(input logic [31:0] w, input logic start);
		push_raw({w[7:0], w[15:8], w[23:16], w[31:24]}, start);
	endtask

	function automatic logic [31:0] nonzero_bytes();
		return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
	endfunction

	// One structure block, mostly well formed, with occasional truncation and noise.
	task automatic gen_block();
		int n;
		int r;
		int nval;
		logic st;
		logic [31:0] len;
		logic [31:0] x;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 10))
				push_raw($urandom(), $urandom_range(0, 3) == 0);
			return;
		end
		st = 1'b1;
		n = $urandom_range(1, 24);
		repeat (n) begin
			r = $urandom_range(0, 29);
			if (r < 6) begin
				push_tok(TOK_BEGIN_NODE, st);
				repeat ($urandom_range(0, 3))
					push_raw(nonzero_bytes(), 1'b0);
				x = nonzero_bytes();
				x[8 * $urandom_range(0, 3) +: 8] = 8'h00;
				if ($urandom_range(0, 3) == 0)
					x[8 * $urandom_range(0, 3) +: 8] = 8'h00;
				push_raw(x, 1'b0);
			end else if (r < 18) begin
				push_tok(TOK_PROP, st);
				len = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 20);
				push_tok(len, 1'b0);
				push_tok($urandom(), 1'b0);
				nval = (len > 40) ? $urandom_range(0, 4) : int'((len + 3) / 4);
				if (nval > 0 && $urandom_range(0, 15) == 0)
					nval--;
				repeat (nval)
					push_raw($urandom(), 1'b0);
			end else if (r < 21) begin
				push_tok(TOK_NOP, st);
			end else if (r < 24) begin
				push_tok(TOK_END_NODE, st);
			end else if (r < 26) begin
				push_tok(TOK_END, st);
			end else if (r == 26) begin
				x = $urandom_range(0, 1) ? 32'($urandom()) : 32'($urandom_range(0, 12));
				push_tok(x, st);
				repeat ($urandom_range(0, 3))
					push_raw($urandom(), 1'b0);
			end else if (r == 27) begin
				push_tok(TOK_PROP, 1'b1);
			end else if (r == 28) begin
				push_raw($urandom(), st);
			end else begin
				push_tok(TOK_NOP, 1'b1);
			end
			st = 1'b0;
		end
	endtask

	task automatic set_size(input logic [20:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cur_size = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (words_q.size() != 0 || s_tvalid || events_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive
		logic take;
		logic nv;
		walk_item_t it;
		if (arst_n) begin
			take = s_tvalid && s_tready;
			if (take)
				walk_word(s_tdata, s_tuser[0]);
			if (!s_tvalid || take) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (words_q.size() != 0) begin
					it = words_q.pop_front();
					nv = 1'b1;
					s_tdata <= it.raw;
					s_tuser <= it.start;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= nv;
			end
		end
	end

	always @(posedge clk) begin : watch
		event_t got;
		event_t want;
		logic rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.event_kind = m_tuser[0];
				got.name_offset = m_tdata[31:0];
				got.value_length = m_tdata[63:32];
				got.value_offset = m_tdata[84:64];
				if (events_due.size() == 0) begin
					bad_events++;
					if (shown < 10) begin
						shown++;
						$display("unexpected event: kind=%0d name=%h len=%h off=%h",
							got.event_kind, got.name_offset, got.value_length,
							got.value_offset);
					end
				end else begin
					want = events_due.pop_front();
					if (got.event_kind !== want.event_kind ||
							got.name_offset !== want.name_offset ||
							got.value_length !== want.value_length ||
							got.value_offset !== want.value_offset) begin
						bad_events++;
						if (shown < 10) begin
							shown++;
							$display("event mismatch: exp kind=%0d name=%h len=%h off=%h",
								want.event_kind, want.name_offset, want.value_length,
								want.value_offset);
							$display("                got kind=%0d name=%h len=%h off=%h",
								got.event_kind, got.name_offset, got.value_length,
								got.value_offset);
						end
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 300);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = (rx_left % 5 != 0) && (rx_left % 7 != 3);
			endcase
			m_tready <= rdy && !long_hold;
		end
	end

	assign long_hold = (hold_left != 0);

	always @(posedge clk) begin
		cyc++;
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (cyc % 1200 == 500)
			hold_left <= 400;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("fdt_struct_block_walker_test NOT OK");
			$finish;
		end
	end

	initial begin
		int r;
		int target;
		logic [20:0] sz;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// At the reset size every item falls beyond the block and is dropped.
		push_tok(TOK_PROP, 1'b1);
		push_tok(32'd4, 1'b0);
		push_tok(32'd7, 1'b0);
		drain();

		set_size(21'(MAX_BYTES));
		push_tok(TOK_NOP, 1'b1);
		push_tok(TOK_END_NODE, 1'b0);
		push_tok(TOK_END, 1'b0);
		push_tok(TOK_BEGIN_NODE, 1'b0);
		push_raw(32'h64636261, 1'b0);
		push_raw(32'h00636261, 1'b0);
		push_tok(TOK_BEGIN_NODE, 1'b0);
		push_raw(32'h61626300, 1'b0);
		push_tok(TOK_BEGIN_NODE, 1'b0);
		push_raw(32'h61610061, 1'b0);
		push_tok(TOK_PROP, 1'b0);
		push_tok(32'd0, 1'b0);
		push_tok(32'd0, 1'b0);
		push_tok(TOK_PROP, 1'b0);
		push_tok(32'd5, 1'b0);
		push_tok(32'hFFFFFFFF, 1'b0);
		push_raw(32'hA5A5A5A5, 1'b0);
		push_raw(32'h5A5A5A5A, 1'b0);
		push_tok(TOK_PROP, 1'b0);
		push_tok(32'hFFFFFFFF, 1'b0);
		push_tok(32'h80000000, 1'b0);
		push_tok(32'hFFFFFFFF, 1'b1);
		push_tok(TOK_PROP, 1'b0);
		push_tok(TOK_NOP, 1'b1);
		drain();

		set_size(21'h1FFFFF);
		push_tok(32'd0, 1'b1);
		push_tok(TOK_PROP, 1'b1);
		push_tok(32'd1, 1'b0);
		push_tok(32'd7, 1'b0);
		push_raw(32'h00000000, 1'b0);
		drain();

		// Twelve bytes end the block just before the name-offset word.
		set_size(21'd12);
		push_tok(TOK_NOP, 1'b1);
		push_tok(TOK_PROP, 1'b0);
		push_tok(32'd8, 1'b0);
		push_tok(32'd3, 1'b0);
		drain();

		while (words_made < RANDOM_WORDS + 40) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				sz = 21'(MAX_BYTES);
			else if (r < 4)
				sz = 21'h1FFFFF;
			else if (r < 6)
				sz = 21'($urandom_range(4096, 2097151));
			else if (r < 8)
				sz = 21'($urandom_range(1, 256));
			else if (r == 8)
				sz = ($urandom_range(0, 1) == 0) ? 21'd0 : 21'(MAX_BYTES - 1);
			else
				sz = 21'($urandom_range(0, 2097151));
			set_size(sz);
			target = words_made + $urandom_range(60, 250);
			while (words_made < target)
				gen_block();
			drain();
		end

		drain();
		repeat (16) @(posedge clk);
		bad_events += events_due.size();
		if (bad_events == 0)
			$display("fdt_struct_block_walker_test OK");
		else
			$display("fdt_struct_block_walker_test NOT OK");
		$finish;
	end

endmodule
